[src/adll_pkg.sv]
// types, codes and microcode store of the array-based doubly linked list
package adll_pkg;

  localparam int OPC_W    = 3;
  localparam int STATUS_W = 2;
  localparam int STEP_W   = 4;

  typedef enum logic [OPC_W-1:0] {
    OP_APPEND     = 3'd0,
    OP_INS_BEFORE = 3'd1,
    OP_INS_AFTER  = 3'd2,
    OP_REMOVE     = 3'd3,
    OP_READ       = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_e;

  // sequencing of one control word
  typedef enum logic [1:0] {
    SQ_ACCEPT  = 2'd0,  // wait for a request, then dispatch on opcode
    SQ_CHECK   = 2'd1,  // go on if the check passes, else report
    SQ_END     = 2'd2,  // commit and hand over the result
    SQ_RESTART = 2'd3   // back to idle
  } seq_e;

  typedef enum logic [1:0] {
    CK_NONE     = 2'd0,
    CK_FULL     = 2'd1,
    CK_FULL_POS = 2'd2,
    CK_POS      = 2'd3
  } chk_e;

  // memory write address sources
  typedef enum logic [2:0] {
    AD_NEW  = 3'd0,
    AD_POS  = 3'd1,
    AD_PRED = 3'd2,
    AD_SUCC = 3'd3,
    AD_TAIL = 3'd4
  } addr_e;

  // link value sources
  typedef enum logic [2:0] {
    LK_NONE = 3'd0,
    LK_NEW  = 3'd1,
    LK_POS  = 3'd2,
    LK_PRED = 3'd3,
    LK_SUCC = 3'd4,
    LK_TAIL = 3'd5,
    LK_FREE = 3'd6
  } link_e;

  typedef enum logic [1:0] {
    HD_KEEP            = 2'd0,
    HD_NEW_IF_NO_TAIL  = 2'd1,
    HD_NEW_IF_NO_PRED  = 2'd2,
    HD_SUCC_IF_NO_PRED = 2'd3
  } head_e;

  typedef enum logic [1:0] {
    TL_KEEP            = 2'd0,
    TL_NEW             = 2'd1,
    TL_NEW_IF_NO_SUCC  = 2'd2,
    TL_PRED_IF_NO_SUCC = 2'd3
  } tail_e;

  typedef enum logic [1:0] {
    CN_KEEP = 2'd0,
    CN_INC  = 2'd1,
    CN_DEC  = 2'd2
  } cnt_e;

  typedef enum logic [1:0] {
    FR_KEEP = 2'd0,
    FR_POP  = 2'd1,
    FR_PUSH = 2'd2
  } free_e;

  typedef enum logic [1:0] {
    SL_NONE = 2'd0,
    SL_NEW  = 2'd1,
    SL_POS  = 2'd2
  } slot_e;

  typedef logic [STEP_W-1:0] step_t;

  // microcode addresses
  localparam step_t ST_IDLE   = 4'd0;
  localparam step_t ST_REPORT = 4'd1;
  localparam step_t ST_APP1   = 4'd2;
  localparam step_t ST_APP2   = 4'd3;
  localparam step_t ST_IB1    = 4'd4;
  localparam step_t ST_IB2    = 4'd5;
  localparam step_t ST_IA1    = 4'd6;
  localparam step_t ST_IA2    = 4'd7;
  localparam step_t ST_RM1    = 4'd8;
  localparam step_t ST_RM2    = 4'd9;
  localparam step_t ST_RD1    = 4'd10;
  localparam step_t ST_RD2    = 4'd11;

  typedef struct packed {
    seq_e  seq;
    chk_e  chk;
    logic  nx_we;
    addr_e nx_addr;
    link_e nx_data;
    logic  pv_we;
    addr_e pv_addr;
    link_e pv_data;
    logic  pay_we;
    logic  use_we;
    addr_e use_addr;
    logic  use_val;
    head_e head;
    tail_e tail;
    cnt_e  cnt;
    free_e free;
    slot_e slot;
    logic  rd_out;
  } ctl_t;

  // condition inputs of the sequencer
  typedef struct packed {
    logic             accept;
    logic [OPC_W-1:0] opcode;
    logic             ok;
    logic             fire;
  } seq_cond_t;

  localparam ctl_t CTL_NOP = '{
    seq: SQ_RESTART, chk: CK_NONE,
    nx_we: 1'b0, nx_addr: AD_NEW, nx_data: LK_NONE,
    pv_we: 1'b0, pv_addr: AD_NEW, pv_data: LK_NONE,
    pay_we: 1'b0, use_we: 1'b0, use_addr: AD_NEW, use_val: 1'b0,
    head: HD_KEEP, tail: TL_KEEP, cnt: CN_KEEP, free: FR_KEEP,
    slot: SL_NONE, rd_out: 1'b0
  };

  // control store
  function automatic ctl_t ucode(step_t step);
    ctl_t w;
    w = CTL_NOP;
    unique case (step)
      ST_IDLE: begin
        w.seq = SQ_ACCEPT;
      end
      ST_REPORT: begin
        w.seq = SQ_END;
      end
      ST_APP1: begin
        w.seq = SQ_CHECK;     w.chk = CK_FULL;
        w.nx_we = 1'b1;       w.nx_addr = AD_NEW;  w.nx_data = LK_NONE;
        w.pv_we = 1'b1;       w.pv_addr = AD_NEW;  w.pv_data = LK_TAIL;
        w.pay_we = 1'b1;      w.use_we = 1'b1;     w.use_addr = AD_NEW;
        w.use_val = 1'b1;
      end
      ST_APP2: begin
        w.seq = SQ_END;
        w.nx_we = 1'b1;       w.nx_addr = AD_TAIL; w.nx_data = LK_NEW;
        w.head = HD_NEW_IF_NO_TAIL;                w.tail = TL_NEW;
        w.cnt = CN_INC;       w.free = FR_POP;     w.slot = SL_NEW;
      end
      ST_IB1: begin
        w.seq = SQ_CHECK;     w.chk = CK_FULL_POS;
        w.nx_we = 1'b1;       w.nx_addr = AD_NEW;  w.nx_data = LK_POS;
        w.pv_we = 1'b1;       w.pv_addr = AD_NEW;  w.pv_data = LK_PRED;
        w.pay_we = 1'b1;      w.use_we = 1'b1;     w.use_addr = AD_NEW;
        w.use_val = 1'b1;
      end
      ST_IB2: begin
        w.seq = SQ_END;
        w.nx_we = 1'b1;       w.nx_addr = AD_PRED; w.nx_data = LK_NEW;
        w.pv_we = 1'b1;       w.pv_addr = AD_POS;  w.pv_data = LK_NEW;
        w.head = HD_NEW_IF_NO_PRED;
        w.cnt = CN_INC;       w.free = FR_POP;     w.slot = SL_NEW;
      end
      ST_IA1: begin
        w.seq = SQ_CHECK;     w.chk = CK_FULL_POS;
        w.nx_we = 1'b1;       w.nx_addr = AD_NEW;  w.nx_data = LK_SUCC;
        w.pv_we = 1'b1;       w.pv_addr = AD_NEW;  w.pv_data = LK_POS;
        w.pay_we = 1'b1;      w.use_we = 1'b1;     w.use_addr = AD_NEW;
        w.use_val = 1'b1;
      end
      ST_IA2: begin
        w.seq = SQ_END;
        w.nx_we = 1'b1;       w.nx_addr = AD_POS;  w.nx_data = LK_NEW;
        w.pv_we = 1'b1;       w.pv_addr = AD_SUCC; w.pv_data = LK_NEW;
        w.tail = TL_NEW_IF_NO_SUCC;
        w.cnt = CN_INC;       w.free = FR_POP;     w.slot = SL_NEW;
      end
      ST_RM1: begin
        w.seq = SQ_CHECK;     w.chk = CK_POS;
        w.nx_we = 1'b1;       w.nx_addr = AD_PRED; w.nx_data = LK_SUCC;
        w.pv_we = 1'b1;       w.pv_addr = AD_SUCC; w.pv_data = LK_PRED;
        w.use_we = 1'b1;      w.use_addr = AD_POS; w.use_val = 1'b0;
      end
      ST_RM2: begin
        w.seq = SQ_END;
        w.nx_we = 1'b1;       w.nx_addr = AD_POS;  w.nx_data = LK_FREE;
        w.head = HD_SUCC_IF_NO_PRED;               w.tail = TL_PRED_IF_NO_SUCC;
        w.cnt = CN_DEC;       w.free = FR_PUSH;    w.slot = SL_POS;
      end
      ST_RD1: begin
        w.seq = SQ_CHECK;     w.chk = CK_POS;
      end
      ST_RD2: begin
        w.seq = SQ_END;       w.slot = SL_POS;     w.rd_out = 1'b1;
      end
      default: begin
        w = CTL_NOP;
      end
    endcase
    return w;
  endfunction

  // entry point of each operation's routine
  function automatic step_t dispatch(logic [OPC_W-1:0] opcode);
    step_t s;
    s = ST_REPORT;
    unique case (op_e'(opcode))
      OP_APPEND:     s = ST_APP1;
      OP_INS_BEFORE: s = ST_IB1;
      OP_INS_AFTER:  s = ST_IA1;
      OP_REMOVE:     s = ST_RM1;
      OP_READ:       s = ST_RD1;
      default:       s = ST_REPORT;
    endcase
    return s;
  endfunction

endpackage

[src/array_doubly_linked_list.sv]
// doubly linked list in a fixed node pool with a free chain, microcoded control
//
// A request carries an opcode (append, insert before, insert after, remove,
// read), a slot position and a payload; every request gives exactly one
// result with status, the slot allocated, removed or read, the read slot's
// payload and links, and the head, tail and node count after the request.
// "None" in any slot field is the value NODES. A full list or a position
// that is not in the list gives a status and leaves everything unchanged.
// Timing: a request is taken in the idle step; append, both inserts, remove
// and read then run a check step and an end step, an unused opcode only the
// report step. Two steps are needed for the link memories: each has one write
// port and an insert touches two links in each, a remove two next links, so
// two write steps follow the reads done on the accept edge. A new request is
// taken while the previous result still waits in the output register; the
// last step of a routine holds until that register is free. Storage is
// plain memories with registered reads; no clearing pass runs after reset:
// a fill mark tells slots never yet allocated, which stand in free order.
module array_doubly_linked_list
  import adll_pkg::*;
#(
  parameter int NODES     = 64,
  parameter int DATA_BITS = 32,
  localparam int IDX_W    = $clog2(NODES),
  localparam int LINK_W   = $clog2(NODES + 1),
  localparam int IN_BITS  = OPC_W + IDX_W + DATA_BITS,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = STATUS_W + 6 * LINK_W + DATA_BITS,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // opcode, position, payload; zero padding above
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // status, slot, payload_out, next_slot, prev_slot, first_slot, last_slot,
  // count; zero padding above
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(NODES);

  // request fields
  logic [OPC_W-1:0]     in_op;
  logic [IDX_W-1:0]     in_pos;
  logic [DATA_BITS-1:0] in_pay;

  assign in_op  = s_axis_tdata[OPC_W-1:0];
  assign in_pos = s_axis_tdata[OPC_W +: IDX_W];
  assign in_pay = s_axis_tdata[OPC_W + IDX_W +: DATA_BITS];

  // sequencer
  ctl_t      ctl;
  seq_cond_t cond;

  adll_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .ctl_o  (ctl)
  );

  // list state
  logic [LINK_W-1:0] head_q, head_d;
  logic [LINK_W-1:0] tail_q, tail_d;
  logic [LINK_W-1:0] free_q, free_d;   // head of the free chain
  logic [LINK_W-1:0] fill_q, fill_d;   // slots at or above it never allocated
  logic [LINK_W-1:0] count_q, count_d;
  status_e           status_q;

  // request held for the routine
  logic [IDX_W-1:0]     pos_q;
  logic [DATA_BITS-1:0] data_q;

  // memories and their registered read data
  logic [LINK_W-1:0]    next_mem [NODES];
  logic [LINK_W-1:0]    prev_mem [NODES];
  logic [DATA_BITS-1:0] pay_mem  [NODES];
  logic                 used_mem [NODES];

  logic [LINK_W-1:0]    nxp_q;   // successor of the position
  logic [LINK_W-1:0]    prp_q;   // predecessor of the position
  logic [LINK_W-1:0]    nxf_q;   // link behind the free head
  logic [DATA_BITS-1:0] payr_q;
  logic                 used_q;

  // output register
  logic             out_valid_q;
  logic [OUT_W-1:0] out_q;

  // handshake and step control
  logic    accept;
  logic    go;
  logic    finish;
  logic    full;
  logic    listed;
  logic    ok;
  status_e chk_status;

  logic [LINK_W-1:0] pos_s;

  assign pos_s         = LINK_W'(pos_q);
  assign s_axis_tready = (ctl.seq == SQ_ACCEPT);
  assign accept        = s_axis_tvalid && s_axis_tready;
  // the final step of a routine waits for room in the output register
  assign go            = (ctl.seq != SQ_END) || !out_valid_q || m_axis_tready;
  assign finish        = (ctl.seq == SQ_END) && go;

  // checks are made on read data fetched on the accept edge
  assign full   = (count_q == NONE_LINK);
  assign listed = (pos_s < fill_q) && used_q;

  always_comb begin
    unique case (ctl.chk)
      CK_NONE:     chk_status = STAT_OK;
      CK_FULL:     chk_status = full ? STAT_FULL : STAT_OK;
      CK_FULL_POS: chk_status = full ? STAT_FULL : (listed ? STAT_OK : STAT_BAD);
      CK_POS:      chk_status = listed ? STAT_OK : STAT_BAD;
    endcase
  end

  assign ok = (chk_status == STAT_OK);

  assign cond.accept = accept;
  assign cond.opcode = in_op;
  assign cond.ok     = ok;
  assign cond.fire   = go;

  function automatic logic [LINK_W-1:0] pick_addr(
    addr_e             sel,
    logic [LINK_W-1:0] new_s,
    logic [LINK_W-1:0] pos_v,
    logic [LINK_W-1:0] pred_s,
    logic [LINK_W-1:0] succ_s,
    logic [LINK_W-1:0] tail_s
  );
    logic [LINK_W-1:0] a;
    unique case (sel)
      AD_NEW:  a = new_s;
      AD_POS:  a = pos_v;
      AD_PRED: a = pred_s;
      AD_SUCC: a = succ_s;
      AD_TAIL: a = tail_s;
      default: a = new_s;
    endcase
    return a;
  endfunction

  function automatic logic [LINK_W-1:0] pick_link(
    link_e             sel,
    logic [LINK_W-1:0] new_s,
    logic [LINK_W-1:0] pos_v,
    logic [LINK_W-1:0] pred_s,
    logic [LINK_W-1:0] succ_s,
    logic [LINK_W-1:0] tail_s,
    logic [LINK_W-1:0] free_s
  );
    logic [LINK_W-1:0] v;
    unique case (sel)
      LK_NONE: v = NONE_LINK;
      LK_NEW:  v = new_s;
      LK_POS:  v = pos_v;
      LK_PRED: v = pred_s;
      LK_SUCC: v = succ_s;
      LK_TAIL: v = tail_s;
      LK_FREE: v = free_s;
      default: v = NONE_LINK;
    endcase
    return v;
  endfunction

  // write ports; the new slot is always the free head
  logic [LINK_W-1:0] nx_wa, nx_wd, pv_wa, pv_wd, use_wa;
  logic              nx_we, pv_we, pay_we, use_we;

  assign nx_wa  = pick_addr(ctl.nx_addr, free_q, pos_s, prp_q, nxp_q, tail_q);
  assign nx_wd  = pick_link(ctl.nx_data, free_q, pos_s, prp_q, nxp_q, tail_q, free_q);
  assign pv_wa  = pick_addr(ctl.pv_addr, free_q, pos_s, prp_q, nxp_q, tail_q);
  assign pv_wd  = pick_link(ctl.pv_data, free_q, pos_s, prp_q, nxp_q, tail_q, free_q);
  assign use_wa = pick_addr(ctl.use_addr, free_q, pos_s, prp_q, nxp_q, tail_q);

  // a link to "none" is never written through
  assign nx_we  = ctl.nx_we  && ok && go && (nx_wa != NONE_LINK);
  assign pv_we  = ctl.pv_we  && ok && go && (pv_wa != NONE_LINK);
  assign pay_we = ctl.pay_we && ok && go;
  assign use_we = ctl.use_we && ok && go && (use_wa != NONE_LINK);

  always_ff @(posedge clk_i) begin
    if (nx_we) next_mem[nx_wa[IDX_W-1:0]] <= nx_wd;
    if (accept) begin
      nxp_q <= next_mem[in_pos];
      nxf_q <= next_mem[free_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pv_we) prev_mem[pv_wa[IDX_W-1:0]] <= pv_wd;
    if (accept) prp_q <= prev_mem[in_pos];
  end

  always_ff @(posedge clk_i) begin
    if (pay_we) pay_mem[free_q[IDX_W-1:0]] <= data_q;
    if (accept) payr_q <= pay_mem[in_pos];
  end

  always_ff @(posedge clk_i) begin
    if (use_we) used_mem[use_wa[IDX_W-1:0]] <= ctl.use_val;
    if (accept) used_q <= used_mem[in_pos];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q  <= in_pos;
      data_q <= in_pay;
    end
  end

  // head, tail, count and free chain move only when a routine finishes
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    free_d  = free_q;
    fill_d  = fill_q;
    if (finish) begin
      unique case (ctl.head)
        HD_KEEP:            head_d = head_q;
        HD_NEW_IF_NO_TAIL:  if (tail_q == NONE_LINK) head_d = free_q;
        HD_NEW_IF_NO_PRED:  if (prp_q == NONE_LINK) head_d = free_q;
        HD_SUCC_IF_NO_PRED: if (prp_q == NONE_LINK) head_d = nxp_q;
      endcase
      unique case (ctl.tail)
        TL_KEEP:            tail_d = tail_q;
        TL_NEW:             tail_d = free_q;
        TL_NEW_IF_NO_SUCC:  if (nxp_q == NONE_LINK) tail_d = free_q;
        TL_PRED_IF_NO_SUCC: if (nxp_q == NONE_LINK) tail_d = prp_q;
      endcase
      unique case (ctl.cnt)
        CN_KEEP: count_d = count_q;
        CN_INC:  count_d = LINK_W'(count_q + 1'b1);
        CN_DEC:  count_d = LINK_W'(count_q - 1'b1);
        default: count_d = count_q;
      endcase
      unique case (ctl.free)
        FR_KEEP: free_d = free_q;
        FR_POP: begin
          // a never-used slot links on to the next one in order
          if (free_q == fill_q) begin
            free_d = LINK_W'(fill_q + 1'b1);
            fill_d = LINK_W'(fill_q + 1'b1);
          end else begin
            free_d = nxf_q;
          end
        end
        FR_PUSH: free_d = pos_s;
        default: free_d = free_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= NONE_LINK;
      tail_q   <= NONE_LINK;
      free_q   <= '0;
      fill_q   <= '0;
      count_q  <= '0;
      status_q <= STAT_OK;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      free_q  <= free_d;
      fill_q  <= fill_d;
      count_q <= count_d;
      if (accept) begin
        status_q <= STAT_OK;
      end else if (ctl.chk != CK_NONE) begin
        status_q <= chk_status;
      end
    end
  end

  // result assembly
  logic [LINK_W-1:0]    out_slot, out_next, out_prev;
  logic [DATA_BITS-1:0] out_pay;

  always_comb begin
    unique case (ctl.slot)
      SL_NONE: out_slot = NONE_LINK;
      SL_NEW:  out_slot = free_q;
      SL_POS:  out_slot = pos_s;
      default: out_slot = NONE_LINK;
    endcase
  end

  assign out_pay  = ctl.rd_out ? payr_q : '0;
  assign out_next = ctl.rd_out ? nxp_q : NONE_LINK;
  assign out_prev = ctl.rd_out ? prp_q : NONE_LINK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q <= OUT_W'({count_d, tail_d, head_d, out_prev, out_next, out_pay,
                       out_slot, status_q});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef ASSERT_OFF
  // an empty list has neither head nor tail, a non-empty one has both
  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((count_q == '0) == (head_q == NONE_LINK)) &&
    ((count_q == '0) == (tail_q == NONE_LINK)))
    else $error("head/tail disagree with node count");

  // free head never points past the fill mark, and the count stays within it
  a_free_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q <= fill_q) && (count_q <= fill_q))
    else $error("free head or count beyond fill mark");

  // while not full the free chain offers a real slot
  a_free_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != NONE_LINK) |-> (free_q != NONE_LINK))
    else $error("free chain empty while list not full");

  // each routine takes at least one step after the accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("request taken back to back");
`endif

endmodule

[src/adll_seq.sv]
// microcode sequencer: step counter, control store and jumps
module adll_seq
  import adll_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  seq_cond_t cond_i,
  output ctl_t      ctl_o
);

  step_t step_q, step_d;

  assign ctl_o = ucode(step_q);

  always_comb begin
    step_d = step_q;
    unique case (ctl_o.seq)
      SQ_ACCEPT: begin
        if (cond_i.accept) step_d = dispatch(cond_i.opcode);
      end
      SQ_CHECK: begin
        step_d = cond_i.ok ? step_t'(step_q + 1'b1) : ST_REPORT;
      end
      SQ_END: begin
        if (cond_i.fire) step_d = ST_IDLE;
      end
      SQ_RESTART: begin
        step_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule
